### hw/rtl/perlin_noise_fbm_2d_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractal noise core
// Same-cycle and next-cycle implication checks, clocked on i_clk and
// disabled while i_rst_n is low. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_FBM_2D_CORE_MACROS_SVH
`define PERLIN_NOISE_FBM_2D_CORE_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PNF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PNF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PNF_ASSERT_NOW(lbl, ante, cons)
`define PNF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/pnf2d_pkg.sv
// ----------------------------------------------------------------------------
// Fractal noise package
// Shared constants, datapath operation codes and controller interface types.
// ----------------------------------------------------------------------------
package pnf2d_pkg;

    // Fixed sizes of the block.
    localparam int TABLE_SIZE      = 256;
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LACUN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

    // Configuration reset values.
    localparam logic [3:0]  OCTAVES_RST = 4'd4;
    localparam logic [15:0] LACUN_RST   = 16'd8192;
    localparam logic [15:0] GAIN_RST    = 16'd16384;

    // Input mode codes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Datapath operation codes.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE  = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
    localparam logic [OP_W-1:0] OP_START = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 5'd3;
    localparam logic [OP_W-1:0] OP_F1    = 5'd4;
    localparam logic [OP_W-1:0] OP_F2    = 5'd5;
    localparam logic [OP_W-1:0] OP_F3    = 5'd6;
    localparam logic [OP_W-1:0] OP_F4    = 5'd7;
    localparam logic [OP_W-1:0] OP_F5    = 5'd8;
    localparam logic [OP_W-1:0] OP_F6    = 5'd9;
    localparam logic [OP_W-1:0] OP_F7    = 5'd10;
    localparam logic [OP_W-1:0] OP_GRAD  = 5'd11;
    localparam logic [OP_W-1:0] OP_LERPX = 5'd12;
    localparam logic [OP_W-1:0] OP_LERPY = 5'd13;
    localparam logic [OP_W-1:0] OP_TERM  = 5'd14;
    localparam logic [OP_W-1:0] OP_ACC   = 5'd15;
    localparam logic [OP_W-1:0] OP_DCHK  = 5'd16;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd17;
    localparam logic [OP_W-1:0] OP_OUT   = 5'd18;

    // Quotient bits produced by the divider.
    localparam int QUOT_W = 16;
    localparam int BIT_W  = 4;

    // Command from controller to datapath.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BIT_W-1:0] div_bit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic early;
    } t_sts;

endpackage

### hw/rtl/pnf2d_ctrl.sv
// ----------------------------------------------------------------------------
// Fractal noise controller
// Sequences table loads, the octave steps, the division and the result hand-off.
// ----------------------------------------------------------------------------
module pnf2d_ctrl
    import pnf2d_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_mode,
    input  logic [3:0] i_octave_count,
    input  logic       i_out_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_in_stall,
    output logic       o_out_valid
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_MUL   = 5'd1;
    localparam logic [4:0] ST_F1    = 5'd2;
    localparam logic [4:0] ST_F2    = 5'd3;
    localparam logic [4:0] ST_F3    = 5'd4;
    localparam logic [4:0] ST_F4    = 5'd5;
    localparam logic [4:0] ST_F5    = 5'd6;
    localparam logic [4:0] ST_F6    = 5'd7;
    localparam logic [4:0] ST_F7    = 5'd8;
    localparam logic [4:0] ST_GRAD  = 5'd9;
    localparam logic [4:0] ST_LERPX = 5'd10;
    localparam logic [4:0] ST_LERPY = 5'd11;
    localparam logic [4:0] ST_TERM  = 5'd12;
    localparam logic [4:0] ST_ACC   = 5'd13;
    localparam logic [4:0] ST_DCHK  = 5'd14;
    localparam logic [4:0] ST_DIV   = 5'd15;
    localparam logic [4:0] ST_FIN   = 5'd16;

    logic [4:0]       r_state, n_state;
    logic [OCT_W-1:0] r_oct, n_oct;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;
    logic [4:0]       w_cnt_ext;
    logic [OCT_W-1:0] w_octs;
    logic             w_accept;
    logic             w_out_take;

    // Octave count saturates at the supported maximum.
    assign w_cnt_ext = (5'(i_octave_count) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                             : 5'(i_octave_count);
    assign w_octs    = w_cnt_ext[OCT_W-1:0];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_take  = r_out_valid && !i_out_stall;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_oct       = r_oct;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !w_out_take;
        o_cmd.op      = OP_IDLE;
        o_cmd.div_bit = r_bit;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_START;
                        n_oct    = '0;
                        n_state  = (w_octs == '0) ? ST_DCHK : ST_MUL;
                    end
                end
            end
            ST_MUL:   begin o_cmd.op = OP_MUL;   n_state = ST_F1;    end
            ST_F1:    begin o_cmd.op = OP_F1;    n_state = ST_F2;    end
            ST_F2:    begin o_cmd.op = OP_F2;    n_state = ST_F3;    end
            ST_F3:    begin o_cmd.op = OP_F3;    n_state = ST_F4;    end
            ST_F4:    begin o_cmd.op = OP_F4;    n_state = ST_F5;    end
            ST_F5:    begin o_cmd.op = OP_F5;    n_state = ST_F6;    end
            ST_F6:    begin o_cmd.op = OP_F6;    n_state = ST_F7;    end
            ST_F7:    begin o_cmd.op = OP_F7;    n_state = ST_GRAD;  end
            ST_GRAD:  begin o_cmd.op = OP_GRAD;  n_state = ST_LERPX; end
            ST_LERPX: begin o_cmd.op = OP_LERPX; n_state = ST_LERPY; end
            ST_LERPY: begin o_cmd.op = OP_LERPY; n_state = ST_TERM;  end
            ST_TERM:  begin o_cmd.op = OP_TERM;  n_state = ST_ACC;   end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_oct    = OCT_W'(r_oct + 1'b1);
                n_state  = (n_oct == w_octs) ? ST_DCHK : ST_MUL;
            end
            ST_DCHK: begin
                o_cmd.op = OP_DCHK;
                n_bit    = BIT_W'(QUOT_W - 1);
                n_state  = i_sts.early ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_bit    = BIT_W'(r_bit - 1'b1);
                if (r_bit == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // The result register is reloaded only once it is free.
                if (!r_out_valid || w_out_take) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oct       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oct       <= n_oct;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/pnf2d_dpath.sv
// ----------------------------------------------------------------------------
// Fractal noise datapath
// Permutation memory, lattice hashing, fade, gradients, interpolation,
// octave accumulation and the bit-serial normalizing divider.
// ----------------------------------------------------------------------------
module pnf2d_dpath
    import pnf2d_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [7:0]         i_perm_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic [15:0]        i_lacunarity,
    input  logic [15:0]        i_gain,
    output t_sts               o_sts,
    output logic [15:0]        o_noise_value
);

    localparam int NORM_W = 32 + $clog2(MAX_OCTAVES + 1);

    // Q0.16 product, floored.
    function automatic logic [15:0] fmul(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = a * b;
        return p[31:16];
    endfunction

    // 6t^5 - 15t^4 + 10t^3, clamped to [0, 1.0].
    function automatic logic [16:0] fpoly(input logic [15:0] t3, input logic [15:0] t4,
                                          input logic [15:0] t5);
        logic signed [22:0] f;
        f = 23'sd6 * $signed({7'b0, t5}) - 23'sd15 * $signed({7'b0, t4})
            + 23'sd10 * $signed({7'b0, t3});
        if (f < 0) begin
            return 17'd0;
        end else if (f > 23'sd65536) begin
            return 17'd65536;
        end else begin
            return f[16:0];
        end
    endfunction

    // Eight-direction gradient: +-u +- 2v.
    function automatic logic signed [19:0] grad(input logic [7:0] h,
                                               input logic signed [16:0] x,
                                               input logic signed [16:0] y);
        logic signed [19:0] u, v, su, sv;
        u  = h[2] ? 20'(y) : 20'(x);
        v  = h[2] ? 20'(x) : 20'(y);
        su = h[0] ? -u : u;
        sv = h[1] ? -(v <<< 1) : (v <<< 1);
        return su + sv;
    endfunction

    // a + floor(t * (b - a) / 65536).
    function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
                                               input logic signed [19:0] b,
                                               input logic [16:0] t);
        logic signed [20:0] d;
        logic signed [38:0] p;
        d = 21'(b) - 21'(a);
        p = d * $signed({1'b0, t});
        p = p >>> 16;
        return a + p[19:0];
    endfunction

    logic [7:0]               r_perm [TABLE_SIZE];
    logic [7:0]               r_mem_q;
    logic [7:0]               w_raddr;
    logic signed [31:0]       r_xs, r_ys;
    logic [31:0]              r_freq, r_amp;
    logic signed [63:0]       r_sum;
    logic [NORM_W-1:0]        r_norm;
    logic [23:0]              r_px, r_py;
    logic [15:0]              r_x2, r_x3, r_x4, r_x5, r_y2, r_y3, r_y4, r_y5;
    logic [16:0]              r_fu, r_fv;
    logic [7:0]               r_ha, r_hb, r_aa, r_ab, r_ba, r_bb;
    logic signed [19:0]       r_gaa, r_gba, r_gab, r_gbb;
    logic signed [19:0]       r_x1, r_xx2, r_r;
    logic signed [52:0]       r_term;
    logic [63:0]              r_rem;
    logic [QUOT_W-1:0]        r_quot, r_out;
    logic signed [64:0]       w_pxp, w_pyp;
    logic [47:0]              w_fprod, w_aprod;
    logic signed [19:0]       w_p;
    logic [63:0]              w_trial, w_satlim;
    logic                     w_zero, w_sat;
    logic [7:0]               w_xi, w_yi;
    logic [15:0]              w_xf, w_yf;

    assign w_xi = r_px[23:16];
    assign w_yi = r_py[23:16];
    assign w_xf = r_px[15:0];
    assign w_yf = r_py[15:0];

    // Scaled coordinates in Q32.32; only bits 16 to 39 matter.
    assign w_pxp = r_xs * $signed({1'b0, r_freq});
    assign w_pyp = r_ys * $signed({1'b0, r_freq});

    assign w_fprod = r_freq * i_lacunarity;
    assign w_aprod = r_amp * i_gain;

    // Octave value r/2 + 1/2 in Q.16.
    assign w_p = {r_r[19], r_r[19:1]} + 20'sd32768;

    // Divider compare values.
    assign w_trial  = 64'(r_norm) << i_cmd.div_bit;
    assign w_satlim = 64'({r_norm, 16'h0000});
    assign w_zero   = (r_sum <= 0);
    assign w_sat    = ($unsigned(r_sum) >= w_satlim);
    assign o_sts.early = w_zero || w_sat;

    // Table read address for the hash chain.
    always_comb begin
        case (i_cmd.op)
            OP_F1:   w_raddr = w_xi;
            OP_F2:   w_raddr = w_xi + 8'd1;
            OP_F3:   w_raddr = r_ha + w_yi;
            OP_F4:   w_raddr = r_ha + w_yi + 8'd1;
            OP_F5:   w_raddr = r_hb + w_yi;
            OP_F6:   w_raddr = r_hb + w_yi + 8'd1;
            default: w_raddr = 8'd0;
        endcase
    end

    // Permutation memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_perm[i_perm_index] <= i_perm_value;
        end
        r_mem_q <= r_perm[w_raddr];
    end

    // Datapath registers, one step per command.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_xs   <= i_x_coord;
                r_ys   <= i_y_coord;
                r_freq <= 32'h0001_0000;
                r_amp  <= 32'd32768;
                r_sum  <= '0;
                r_norm <= '0;
            end
            OP_MUL: begin
                r_px <= w_pxp[39:16];
                r_py <= w_pyp[39:16];
            end
            OP_F1: begin
                r_x2 <= fmul(w_xf, w_xf);
                r_y2 <= fmul(w_yf, w_yf);
            end
            OP_F2: begin
                r_x3 <= fmul(r_x2, w_xf);
                r_y3 <= fmul(r_y2, w_yf);
                r_ha <= r_mem_q;
            end
            OP_F3: begin
                r_x4 <= fmul(r_x3, w_xf);
                r_y4 <= fmul(r_y3, w_yf);
                r_hb <= r_mem_q;
            end
            OP_F4: begin
                r_x5 <= fmul(r_x4, w_xf);
                r_y5 <= fmul(r_y4, w_yf);
                r_aa <= r_mem_q;
            end
            OP_F5: begin
                r_fu <= fpoly(r_x3, r_x4, r_x5);
                r_fv <= fpoly(r_y3, r_y4, r_y5);
                r_ab <= r_mem_q;
            end
            OP_F6: r_ba <= r_mem_q;
            OP_F7: r_bb <= r_mem_q;
            OP_GRAD: begin
                // The far corner offset, f - 1.0, is the fraction with a set sign bit.
                r_gaa <= grad(r_aa, {1'b0, w_xf}, {1'b0, w_yf});
                r_gba <= grad(r_ba, {1'b1, w_xf}, {1'b0, w_yf});
                r_gab <= grad(r_ab, {1'b0, w_xf}, {1'b1, w_yf});
                r_gbb <= grad(r_bb, {1'b1, w_xf}, {1'b1, w_yf});
            end
            OP_LERPX: begin
                r_x1  <= lerp(r_gaa, r_gba, r_fu);
                r_xx2 <= lerp(r_gab, r_gbb, r_fu);
            end
            OP_LERPY: r_r <= lerp(r_x1, r_xx2, r_fv);
            OP_TERM:  r_term <= $signed({1'b0, r_amp}) * w_p;
            OP_ACC: begin
                r_sum  <= r_sum + 64'(r_term);
                r_norm <= r_norm + NORM_W'(r_amp);
                r_amp  <= w_aprod[46:15];
                r_freq <= (|w_fprod[47:44]) ? 32'hFFFF_FFFF : w_fprod[43:12];
            end
            OP_DCHK: begin
                r_rem  <= r_sum;
                r_quot <= (!w_zero && w_sat) ? '1 : '0;
            end
            OP_DIV: begin
                if (r_rem >= w_trial) begin
                    r_rem                  <= r_rem - w_trial;
                    r_quot[i_cmd.div_bit] <= 1'b1;
                end
            end
            OP_OUT: r_out <= r_quot;
            default: ;
        endcase
    end

    assign o_noise_value = r_out;

endmodule

### hw/rtl/perlin_noise_fbm_2d_core.sv
// ----------------------------------------------------------------------------
// Fractal gradient noise core
// Two-dimensional gradient noise summed over octaves and normalized to Q0.16.
//
//   channel  signals                                   word
//   in       i_in_valid / o_in_stall                   mode, table entry, x, y
//   out      o_out_valid / i_out_stall                 noise value
//   cfg      i_cfg_we, i_cfg_index, i_cfg_data         one register
//
// A load word is written straight into the table. A sample walks serially through
// the single-port permutation memory and the fade multiplies for each octave,
// and also passes the accept, the range check, the 16-step divider and the
// hand-off. The divider is skipped when the sum is not positive or saturates.
// The input stalls while a sample runs. A stalled result delays the next hand-off.
// Reset is synchronous and restores the register defaults; the table is not
// cleared. A stalled result stays in its register while the next word loads.
// ----------------------------------------------------------------------------
`include "perlin_noise_fbm_2d_core_macros.svh"

module perlin_noise_fbm_2d_core
    import pnf2d_pkg::*;
#(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [7:0]            i_perm_index,
    input  logic [7:0]            i_perm_value,
    input  logic signed [31:0]    i_x_coord,
    input  logic signed [31:0]    i_y_coord,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_noise_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0]  r_octave_count;
    logic [15:0] r_lacunarity;
    logic [15:0] r_gain;
    t_cmd        w_cmd;
    t_sts        w_sts;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCTAVES_RST;
            r_lacunarity   <= LACUN_RST;
            r_gain         <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OCTAVES: r_octave_count <= i_cfg_data[3:0];
                CFG_LACUN:   r_lacunarity   <= i_cfg_data;
                CFG_GAIN:    r_gain         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pnf2d_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_mode        (i_mode),
        .i_octave_count(r_octave_count),
        .i_out_stall   (i_out_stall),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid)
    );

    pnf2d_dpath #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_perm_index (i_perm_index),
        .i_perm_value (i_perm_value),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_lacunarity (r_lacunarity),
        .i_gain       (r_gain),
        .o_sts        (w_sts),
        .o_noise_value(o_noise_value)
    );

    // A sample keeps the input side busy while it is computed.
    `PNF_ASSERT_NEXT(a_sample_busy, i_in_valid && !o_in_stall && i_mode == MODE_SAMPLE, o_in_stall)
    // A table load leaves the input side free in the next cycle.
    `PNF_ASSERT_NEXT(a_load_quick, i_in_valid && !o_in_stall && i_mode == MODE_LOAD, !o_in_stall)
    // A new result appears only as a sample completes.
    `PNF_ASSERT_NOW(a_result_from_sample, $rose(o_out_valid), $past(o_in_stall) && !o_in_stall)

endmodule

### test/perlin_noise_fbm_2d_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the fractal gradient noise core
// Loads the whole permutation table, then sends directed and random sample
// and load words under several register settings with random idling on both
// channels. A scoreboard predicts every noise value and checks each result.
// ----------------------------------------------------------------------------
module perlin_noise_fbm_2d_core_tb;
    import pnf2d_pkg::*;

    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 1700;

    // Scoreboard: predicts noise values and checks them in order.
    class noise_scoreboard;
        logic [7:0]  perm_table [TABLE_SIZE];
        logic [3:0]  octaves;
        logic [15:0] lacunarity;
        logic [15:0] gain;
        logic [15:0] noise_expected [$];
        int          errors;
        int          samples_checked;

        function void init();
            octaves    = OCTAVES_RST;
            lacunarity = LACUN_RST;
            gain       = GAIN_RST;
            errors     = 0;
            samples_checked = 0;
            foreach (perm_table[i]) perm_table[i] = 8'd0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == CFG_OCTAVES) octaves = data[3:0];
            else if (idx == CFG_LACUN) lacunarity = data;
            else if (idx == CFG_GAIN) gain = data;
        endfunction

        function longint fade(longint t);
            longint t2, t3, t4, t5, f;
            t2 = (t * t) >>> 16;
            t3 = (t2 * t) >>> 16;
            t4 = (t3 * t) >>> 16;
            t5 = (t4 * t) >>> 16;
            f = 6 * t5 - 15 * t4 + 10 * t3;
            if (f < 0) f = 0;
            if (f > 65536) f = 65536;
            return f;
        endfunction

        function longint blend(longint a, longint b, longint t);
            return a + ((t * (b - a)) >>> 16);
        endfunction

        function longint grad(logic [7:0] h, longint x, longint y);
            longint u, v;
            u = (h[2] == 1'b0) ? x : y;
            v = (h[2] == 1'b0) ? y : x;
            return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
        endfunction

        function logic [7:0] hash(logic [7:0] i);
            return perm_table[i];
        endfunction

        // One octave of gradient noise at a Q32.32 point, mapped to r/2+1/2.
        function longint octave_noise(logic [63:0] px, logic [63:0] py);
            logic [7:0] xi, yi, ha, hb, aa, ab, ba, bb;
            longint xf, yf, fu, fv, x1, x2, r;
            xi = px[39:32];
            yi = py[39:32];
            xf = longint'(px[31:16]);
            yf = longint'(py[31:16]);
            fu = fade(xf);
            fv = fade(yf);
            ha = hash(xi);
            hb = hash(xi + 8'd1);
            aa = hash(ha + yi);
            ab = hash(ha + yi + 8'd1);
            ba = hash(hb + yi);
            bb = hash(hb + yi + 8'd1);
            x1 = blend(grad(aa, xf, yf), grad(ba, xf - 65536, yf), fu);
            x2 = blend(grad(ab, xf, yf - 65536), grad(bb, xf - 65536, yf - 65536), fu);
            r = blend(x1, x2, fv);
            return ((r * 32768) >>> 16) + 32768;
        endfunction

        function logic [15:0] fbm_noise(logic signed [31:0] x, logic signed [31:0] y);
            logic [63:0] xs, ys, freq, amp, norm, nf, q;
            longint sum;
            int n;
            xs = {{32{x[31]}}, x};
            ys = {{32{y[31]}}, y};
            freq = 64'd65536;
            amp = 64'd32768;
            norm = 0;
            sum = 0;
            n = (octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : octaves;
            for (int i = 0; i < n; i++) begin
                sum += longint'(amp) * octave_noise(xs * freq, ys * freq);
                norm += amp;
                amp = (amp * gain) >> 15;
                nf = (freq * lacunarity) >> 12;
                freq = (nf > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nf;
            end
            if (norm == 0 || sum <= 0) return 16'd0;
            q = 64'(sum) / norm;
            return (q > 64'd65535) ? 16'hFFFF : q[15:0];
        endfunction

        // Notes one accepted input word.
        function void note_input(logic mode, logic [7:0] idx, logic [7:0] val,
                                 logic signed [31:0] x, logic signed [31:0] y);
            if (mode == MODE_LOAD) perm_table[idx] = val;
            else noise_expected.push_back(fbm_noise(x, y));
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Checks one accepted result word against the oldest prediction.
        task check_result(logic [15:0] got);
            logic [15:0] want;
            if (noise_expected.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = noise_expected.pop_front();
            samples_checked++;
            if (got !== want) report($sformatf("noise_value got %h want %h", got, want));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_mode = MODE_LOAD;
    logic [7:0]             i_perm_index = '0;
    logic [7:0]             i_perm_value = '0;
    logic signed [31:0]     i_x_coord = '0;
    logic signed [31:0]     i_y_coord = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [15:0]            o_noise_value;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_OCTAVES;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    noise_scoreboard sb = new();
    bit idling_on = 1'b1;
    int quiet_cycles = 0;
    int settings_run = 0;

    perlin_noise_fbm_2d_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Random stalls on the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= idling_on && ($urandom_range(0, 99) < 9);
    end

    // Monitors on both channels, sampled at the accepting edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_mode, i_perm_index, i_perm_value, i_x_coord, i_y_coord);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_noise_value);
    end

    // Watchdog on cycles with no word accepted on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one input word, with an occasional idle gap before it.
    task automatic send_word(logic mode, logic [7:0] idx, logic [7:0] val,
                             logic [31:0] x, logic [31:0] y);
        if (idling_on && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_perm_index <= idx;
        i_perm_value <= val;
        i_x_coord    <= x;
        i_y_coord    <= y;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_sample(logic [31:0] x, logic [31:0] y);
        send_word(MODE_SAMPLE, 8'($urandom), 8'($urandom), x, y);
    endtask

    // Waits until the block is idle, then writes all three registers.
    task automatic apply_setting(logic [3:0] oct, logic [15:0] lac, logic [15:0] gn);
        i_in_valid <= 1'b0;
        while (sb.noise_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_OCTAVES;
        i_cfg_data <= {12'd0, oct};
        @(posedge i_clk);
        i_cfg_index <= CFG_LACUN;
        i_cfg_data <= lac;
        @(posedge i_clk);
        i_cfg_index <= CFG_GAIN;
        i_cfg_data <= gn;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(CFG_OCTAVES, {12'd0, oct});
        sb.set_register(CFG_LACUN, lac);
        sb.set_register(CFG_GAIN, gn);
        settings_run++;
    endtask

    // Coordinates are drawn mostly in full range, sometimes near the origin.
    function automatic logic [31:0] pick_coord();
        if ($urandom_range(0, 3) == 0) return 32'($signed($urandom_range(0, 8191)) - 4096);
        return $urandom;
    endfunction

    task automatic random_words(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 25)
                send_word(MODE_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
            else
                send_sample(pick_coord(), pick_coord());
        end
    endtask

    initial begin
        sb.init();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The table is filled completely before any sample reads it.
        for (int i = 0; i < TABLE_SIZE; i++)
            send_word(MODE_LOAD, 8'(i), 8'($urandom), $urandom, $urandom);

        // Directed samples at the reset settings: origin, extremes, cell edges.
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_FFFF);
        send_sample(32'h0000_8000, 32'h0000_8000);
        send_sample(32'h0001_0000, 32'hFFFF_0000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0012_3456, 32'hFEDC_BA98);
        // Zero octaves give zero.
        apply_setting(4'd0, LACUN_RST, GAIN_RST);
        send_sample(32'h0003_4000, 32'h0001_C000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        // Octave count above the maximum, full lacunarity and gain.
        apply_setting(4'd15, 16'hFFFF, 16'hFFFF);
        send_sample(32'h0003_4000, 32'h0001_C000);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        // Zero lacunarity and zero gain.
        apply_setting(4'd8, 16'h0000, 16'h0000);
        send_sample(32'h0003_4000, 32'h0001_C000);
        send_sample(32'h8000_0000, 32'hFFFF_FFFF);

        // Random phases over several settings, one without any idling.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(OCTAVES_RST, LACUN_RST, GAIN_RST);
                1: apply_setting(4'd1, 16'd4096, 16'd32768);
                2: apply_setting(4'd8, 16'hFFFF, 16'hFFFF);
                3: apply_setting(4'd0, 16'($urandom), 16'($urandom));
                4: apply_setting(4'd15, 16'($urandom), 16'($urandom));
                default: apply_setting(4'($urandom_range(0, 15)), 16'($urandom),
                                       16'($urandom));
            endcase
            idling_on = (ph != 5);
            random_words(RANDOM_WORDS / 8);
        end
        idling_on = 1'b1;
        i_in_valid <= 1'b0;

        while (sb.noise_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d register settings and %0d checked noise samples.",
                 settings_run, sb.samples_checked);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pnf2d_pkg.sv
hw/rtl/pnf2d_ctrl.sv
hw/rtl/pnf2d_dpath.sv
hw/rtl/perlin_noise_fbm_2d_core.sv
test/perlin_noise_fbm_2d_core_tb.sv
